// ----- hdl/raster_line_delta_decoder_assert.svh -----
// Assertion macros for the raster line delta decoder checker.
// Needs signals named clock and reset in the including scope.
`ifndef RASTER_LINE_DELTA_DECODER_ASSERT_SVH
`define RASTER_LINE_DELTA_DECODER_ASSERT_SVH

// Same-cycle implication.
`define RLDD_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rldd check failed");

// Next-cycle implication.
`define RLDD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rldd check failed");

`endif

// ----- hdl/rldd_pkg.sv -----
// Shared types and constants of the raster line delta decoder.
// No dependencies.
package rldd_pkg;

   localparam int DATA_W = 64;

   // Command byte codes and masks
   localparam logic [7:0] CMD_EOP      = 8'h42;
   localparam logic [7:0] CMD_EOL      = 8'h41;
   localparam logic [7:0] CMD_NOP      = 8'h40;
   localparam logic [7:0] FIXED_BYTE   = 8'h43;
   localparam logic [7:0] MASK_TOP3    = 8'he0;
   localparam logic [7:0] MASK_TOP2    = 8'hc0;
   localparam logic [7:0] PFX_EXTEND   = 8'ha0;
   localparam logic [7:0] PFX_LCOPY    = 8'h80;
   localparam logic [7:0] PFX_REPEAT   = 8'h40;
   localparam logic [7:0] PFX_RAW      = 8'h00;
   localparam logic [7:0] PFX_MIXED    = 8'hc0;
   localparam logic [7:0] MASK_LOW5    = 8'h1f;

   // Result status codes
   localparam logic [2:0] STAT_OK       = 3'd0;
   localparam logic [2:0] STAT_UNKNOWN  = 3'd1;
   localparam logic [2:0] STAT_RANGE    = 3'd2;
   localparam logic [2:0] STAT_NO_LINE  = 3'd3;
   localparam logic [2:0] STAT_ODD_PAGE = 3'd4;

   // Register index of line_size
   localparam logic REG_LINE_SIZE = 1'b0;

   typedef enum logic [1:0] {
      PH_CMD     = 2'd0,
      PH_EXT     = 2'd1,
      PH_REPBYTE = 2'd2,
      PH_RAW     = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RUN   = 3'b010,
      ST_FINAL = 3'b100
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic       push;
      logic       src_copy;
      logic [7:0] value;
      logic       final_beat;
      logic       page_end;
      logic [2:0] status;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;
      logic fill_full;
   } stat_type;

endpackage

// ----- hdl/rldd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rldd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- hdl/rldd_ctrl.sv -----
// Controller: command decoder, decode phase state and byte sequencer.
// Depends on rldd_pkg.
module rldd_ctrl #(
   parameter int MAX_LINE_BYTES = 512
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_stream_byte,
   output rldd_pkg::cmd_type                 cmd,
   input  rldd_pkg::stat_type                stat,
   input  logic [$clog2(MAX_LINE_BYTES)-1:0] pos,
   input  logic [$clog2(MAX_LINE_BYTES+1)-1:0] len,
   input  logic                              line_done
);
   import rldd_pkg::*;

   localparam int LW = $clog2(MAX_LINE_BYTES + 1);
   localparam int MaxRun = (MAX_LINE_BYTES > 255) ? MAX_LINE_BYTES : 255;
   localparam int CW = $clog2(MaxRun + 1);

   state_type      state_ff, state_in;
   phase_type      phase_ff, phase_in;
   logic [7:0]     rep_ff, rep_in, raw_ff, raw_in, ext_ff, ext_in;
   logic           parity_ff, parity_in, err_ff, err_in;
   logic [2:0]     code_ff, code_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           copy_ff, copy_in, pe_ff, pe_in;
   logic [7:0]     val_ff, val_in;

   // decoded values for the byte on the request port
   phase_type      d_phase;
   logic [7:0]     d_rep, d_raw, d_ext;
   logic           d_parity, d_pe, d_copy, d_fail;
   logic [2:0]     d_code;
   logic [CW-1:0]  d_cnt;
   logic [2:0]     lo, mid;
   logic [7:0]     ext_mid, ext_lo;
   logic           lo_blocked;

   assign lo  = req_stream_byte[2:0];
   assign mid = req_stream_byte[5:3];
   assign ext_mid = ext_ff + {5'd0, mid};
   assign ext_lo  = ext_ff + {5'd0, lo};
   // copy of lo bytes needs a full line unless lo is zero
   assign lo_blocked = (lo != 3'd0) && !line_done;

   // Command decode
   always_comb begin
      d_phase  = phase_ff;
      d_rep    = rep_ff;
      d_raw    = raw_ff;
      d_ext    = ext_ff;
      d_parity = parity_ff;
      d_pe     = 1'b0;
      d_copy   = 1'b0;
      d_cnt    = '0;
      d_fail   = 1'b0;
      d_code   = code_ff;
      if (!err_ff) begin
         case (phase_ff)
            PH_CMD: begin
               if (req_stream_byte == CMD_EOP) begin
                  if (!parity_ff) begin
                     d_fail = 1'b1;
                     d_code = STAT_ODD_PAGE;
                  end else begin
                     d_parity = 1'b0;
                     d_pe     = 1'b1;
                  end
               end else begin
                  d_parity = !parity_ff;
                  if (req_stream_byte == CMD_EOL) begin
                     if (!line_done) begin
                        d_fail = 1'b1;
                        d_code = STAT_NO_LINE;
                     end else begin
                        d_copy = 1'b1;
                        d_cnt  = CW'(len - LW'(pos));
                     end
                  end else if (req_stream_byte == CMD_NOP) begin
                     d_cnt = '0;
                  end else if ((req_stream_byte & MASK_TOP3) == PFX_EXTEND) begin
                     d_ext   = {req_stream_byte[4:0], 3'd0};
                     d_phase = PH_EXT;
                  end else if ((req_stream_byte & MASK_TOP3) == PFX_LCOPY) begin
                     if ((req_stream_byte & MASK_LOW5) == 8'd0) begin
                        d_fail = 1'b1;
                        d_code = STAT_RANGE;
                     end else if (!line_done) begin
                        d_fail = 1'b1;
                        d_code = STAT_NO_LINE;
                     end else begin
                        d_copy = 1'b1;
                        d_cnt  = CW'({req_stream_byte[4:0], 3'd0});
                     end
                  end else if ((req_stream_byte & MASK_TOP2) == PFX_REPEAT) begin
                     if (lo_blocked) begin
                        d_fail = 1'b1;
                        d_code = STAT_NO_LINE;
                     end else begin
                        d_copy  = 1'b1;
                        d_cnt   = CW'(lo);
                        d_rep   = {5'd0, mid};
                        d_raw   = 8'd0;
                        d_phase = PH_REPBYTE;
                     end
                  end else if ((req_stream_byte & MASK_TOP2) == PFX_RAW) begin
                     if (mid == 3'd0) begin
                        d_fail = 1'b1;
                        d_code = STAT_RANGE;
                     end else if (lo_blocked) begin
                        d_fail = 1'b1;
                        d_code = STAT_NO_LINE;
                     end else begin
                        d_copy  = 1'b1;
                        d_cnt   = CW'(lo);
                        d_raw   = {5'd0, mid};
                        d_phase = PH_RAW;
                     end
                  end else begin
                     // mixed form: copy, fixed-byte repeat or repeat plus raw
                     if (lo != 3'd0 && mid == 3'd0) begin
                        if (!line_done) begin
                           d_fail = 1'b1;
                           d_code = STAT_NO_LINE;
                        end else begin
                           d_copy = 1'b1;
                           d_cnt  = CW'(lo);
                        end
                     end else if (lo == 3'd0 && mid != 3'd0) begin
                        d_cnt = CW'(mid);
                     end else if (lo != 3'd0) begin
                        if (mid < 3'd2) begin
                           d_fail = 1'b1;
                           d_code = STAT_RANGE;
                        end else begin
                           d_rep   = {5'd0, mid};
                           d_raw   = {5'd0, lo};
                           d_phase = PH_REPBYTE;
                        end
                     end else begin
                        d_fail = 1'b1;
                        d_code = STAT_UNKNOWN;
                     end
                  end
               end
            end
            PH_EXT: begin
               d_parity = !parity_ff;
               d_phase  = PH_CMD;
               case (req_stream_byte & MASK_TOP2)
                  PFX_RAW: begin
                     if (ext_mid < 8'd8) begin
                        d_fail = 1'b1;
                        d_code = STAT_RANGE;
                     end else begin
                        d_cnt = CW'(ext_mid);
                     end
                  end
                  PFX_LCOPY: begin
                     if (ext_mid < 8'd8) begin
                        d_fail = 1'b1;
                        d_code = STAT_RANGE;
                     end else if (lo_blocked) begin
                        d_fail = 1'b1;
                        d_code = STAT_NO_LINE;
                     end else begin
                        d_copy  = 1'b1;
                        d_cnt   = CW'(lo);
                        d_rep   = ext_mid;
                        d_raw   = 8'd0;
                        d_phase = PH_REPBYTE;
                     end
                  end
                  PFX_REPEAT: begin
                     if (ext_lo < 8'd8 || mid < 3'd2) begin
                        d_fail = 1'b1;
                        d_code = STAT_RANGE;
                     end else begin
                        d_rep   = {5'd0, mid};
                        d_raw   = ext_lo;
                        d_phase = PH_REPBYTE;
                     end
                  end
                  default: begin
                     if (ext_mid < 8'd8) begin
                        d_fail = 1'b1;
                        d_code = STAT_RANGE;
                     end else if (lo_blocked) begin
                        d_fail = 1'b1;
                        d_code = STAT_NO_LINE;
                     end else begin
                        d_copy  = 1'b1;
                        d_cnt   = CW'(lo);
                        d_raw   = ext_mid;
                        d_phase = PH_RAW;
                     end
                  end
               endcase
            end
            PH_REPBYTE: begin
               d_parity = !parity_ff;
               d_cnt    = CW'(rep_ff);
               d_rep    = 8'd0;
               d_phase  = (raw_ff != 8'd0) ? PH_RAW : PH_CMD;
            end
            default: begin
               d_parity = !parity_ff;
               d_cnt    = CW'(1);
               d_raw    = (raw_ff != 8'd0) ? raw_ff - 8'd1 : raw_ff;
               if (raw_ff <= 8'd1) begin
                  d_phase = PH_CMD;
               end
            end
         endcase
      end
      if (d_fail) begin
         d_phase = PH_CMD;
         d_cnt   = '0;
      end
   end

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      rep_in    = rep_ff;
      raw_in    = raw_ff;
      ext_in    = ext_ff;
      parity_in = parity_ff;
      err_in    = err_ff;
      code_in   = code_ff;
      cnt_in    = cnt_ff;
      copy_in   = copy_ff;
      pe_in     = pe_ff;
      val_in    = val_ff;
      cmd.push       = 1'b0;
      cmd.final_beat = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               phase_in  = d_phase;
               rep_in    = d_rep;
               raw_in    = d_raw;
               ext_in    = d_ext;
               parity_in = d_parity;
               err_in    = err_ff | d_fail;
               code_in   = d_code;
               cnt_in    = d_cnt;
               copy_in   = d_copy;
               pe_in     = d_pe;
               // fixed-byte repeats carry 0x43, the rest carry the stream byte
               val_in    = (!err_ff && ((phase_ff == PH_EXT
                             && (req_stream_byte & MASK_TOP2) == PFX_RAW)
                             || (phase_ff == PH_CMD
                             && (req_stream_byte & MASK_TOP2) == PFX_MIXED
                             && lo == 3'd0))) ? FIXED_BYTE : req_stream_byte;
               state_in  = (d_cnt != '0) ? ST_RUN : ST_FINAL;
            end
         end
         ST_RUN: begin
            // hold while a full chunk waits for the result register
            cmd.push = !(stat.fill_full && !stat.out_free);
            if (cmd.push) begin
               cnt_in = cnt_ff - CW'(1);
               if (cnt_ff == CW'(1)) begin
                  state_in = ST_FINAL;
               end
            end
         end
         ST_FINAL: begin
            if (stat.out_free) begin
               cmd.final_beat = 1'b1;
               pe_in          = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign cmd.src_copy = copy_ff;
   assign cmd.value    = val_ff;
   assign cmd.page_end = pe_ff;
   assign cmd.status   = code_ff;
   assign req_ready    = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         phase_ff  <= PH_CMD;
         rep_ff    <= 8'd0;
         raw_ff    <= 8'd0;
         ext_ff    <= 8'd0;
         parity_ff <= 1'b0;
         err_ff    <= 1'b0;
         code_ff   <= STAT_OK;
         cnt_ff    <= '0;
         copy_ff   <= 1'b0;
         pe_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         rep_ff    <= rep_in;
         raw_ff    <= raw_in;
         ext_ff    <= ext_in;
         parity_ff <= parity_in;
         err_ff    <= err_in;
         code_ff   <= code_in;
         cnt_ff    <= cnt_in;
         copy_ff   <= copy_in;
         pe_ff     <= pe_in;
      end
      val_ff <= val_in;
   end
endmodule

// ----- hdl/rldd_dp.sv -----
// Datapath: line_size register, line ring, position, chunk packing, result register.
// Depends on rldd_pkg and rldd_ram.
module rldd_dp #(
   parameter int MAX_LINE_BYTES   = 512,
   parameter int BYTES_PER_RESULT = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [2:0]                          csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   input  rldd_pkg::cmd_type                   cmd,
   output rldd_pkg::stat_type                  stat,
   output logic [$clog2(MAX_LINE_BYTES)-1:0]   pos,
   output logic [$clog2(MAX_LINE_BYTES+1)-1:0] len,
   output logic                                line_done,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [63:0]                         rsp_out_data,
   output logic [3:0]                          rsp_byte_count,
   output logic                                rsp_page_end,
   output logic [2:0]                          rsp_status,
   output logic                                rsp_last
);
   import rldd_pkg::*;

   localparam int PW = $clog2(MAX_LINE_BYTES);
   localparam int LW = $clog2(MAX_LINE_BYTES + 1);

   logic [9:0]        size_ff, size_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic              done_ff, done_in;
   logic [DATA_W-1:0] chunk_ff, chunk_in;
   logic [3:0]        fill_ff, fill_in;
   logic              byp_ff, byp_in;
   logic [7:0]        byp_data_ff;
   logic [7:0]        ram_rdata, push_byte;
   logic [LW-1:0]     pos_next;
   logic              cfg_write, out_load, out_free;
   logic              ov_ff, ov_in;
   logic [DATA_W-1:0] od_ff, od_in;
   logic [3:0]        oc_ff, oc_in;
   logic              ope_ff, ope_in, olast_ff, olast_in;
   logic [2:0]        ost_ff, ost_in;

   // Register port
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == REG_LINE_SIZE);
   assign csr_prdata = (csr_paddr[2] == REG_LINE_SIZE) ? {22'd0, size_ff} : 32'd0;
   assign size_in    = cfg_write ? csr_pwdata[9:0] : size_ff;

   // Effective line length
   always_comb begin
      if (size_ff == 10'd0) begin
         len = LW'(1);
      end else if (32'(size_ff) > 32'(MAX_LINE_BYTES)) begin
         len = LW'(MAX_LINE_BYTES);
      end else begin
         len = LW'(size_ff);
      end
   end

   // Byte source: line above (with same-address bypass) or given value
   assign push_byte = !cmd.src_copy ? cmd.value : (byp_ff ? byp_data_ff : ram_rdata);
   assign pos_next  = LW'(pos_ff) + LW'(1);

   always_comb begin
      pos_in  = pos_ff;
      done_in = done_ff;
      if (cfg_write) begin
         pos_in  = '0;
         done_in = 1'b0;
      end else if (cmd.push) begin
         if (pos_next >= len) begin
            pos_in  = '0;
            done_in = 1'b1;
         end else begin
            pos_in = PW'(pos_next);
         end
      end
   end
   assign byp_in = cmd.push && (pos_in == pos_ff);

   rldd_ram #(.WIDTH(8), .DEPTH(MAX_LINE_BYTES)) u_ring (
      .clock (clock),
      .we    (cmd.push),
      .waddr (pos_ff),
      .wdata (push_byte),
      .raddr (pos_in),
      .rdata (ram_rdata)
   );

   // Chunk packing and result register
   assign out_free = !ov_ff || rsp_ready;
   assign out_load = (cmd.push && fill_ff == 4'(BYTES_PER_RESULT)) || cmd.final_beat;

   always_comb begin
      chunk_in = chunk_ff;
      fill_in  = fill_ff;
      if (cmd.final_beat) begin
         chunk_in = '0;
         fill_in  = 4'd0;
      end else if (cmd.push) begin
         if (fill_ff == 4'(BYTES_PER_RESULT)) begin
            chunk_in = DATA_W'(push_byte);
            fill_in  = 4'd1;
         end else begin
            chunk_in[fill_ff[2:0]*8 +: 8] = push_byte;
            fill_in = fill_ff + 4'd1;
         end
      end
   end

   always_comb begin
      ov_in    = ov_ff && !rsp_ready;
      od_in    = od_ff;
      oc_in    = oc_ff;
      ope_in   = ope_ff;
      ost_in   = ost_ff;
      olast_in = olast_ff;
      if (out_load) begin
         ov_in    = 1'b1;
         od_in    = chunk_ff;
         oc_in    = fill_ff;
         ope_in   = cmd.final_beat && cmd.page_end;
         ost_in   = cmd.status;
         olast_in = cmd.final_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= 10'd512;
         pos_ff   <= '0;
         done_ff  <= 1'b0;
         chunk_ff <= '0;
         fill_ff  <= 4'd0;
         byp_ff   <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         size_ff  <= size_in;
         pos_ff   <= pos_in;
         done_ff  <= done_in;
         chunk_ff <= chunk_in;
         fill_ff  <= fill_in;
         byp_ff   <= byp_in;
         ov_ff    <= ov_in;
      end
      byp_data_ff <= push_byte;
      od_ff       <= od_in;
      oc_ff       <= oc_in;
      ope_ff      <= ope_in;
      ost_ff      <= ost_in;
      olast_ff    <= olast_in;
   end

   assign stat.out_free  = out_free;
   assign stat.fill_full = (fill_ff == 4'(BYTES_PER_RESULT));
   assign pos            = pos_ff;
   assign line_done      = done_ff;
   assign rsp_valid      = ov_ff;
   assign rsp_out_data   = od_ff;
   assign rsp_byte_count = oc_ff;
   assign rsp_page_end   = ope_ff;
   assign rsp_status     = ost_ff;
   assign rsp_last       = olast_ff;
endmodule

// ----- hdl/raster_line_delta_decoder.sv -----
// Raster line delta decoder: one compressed stream byte in, decoded byte chunks out.
// Usage:
//  - req_*: one command-stream byte per beat (valid/ready).
//  - rsp_*: result beats of up to BYTES_PER_RESULT decoded bytes each; every input
//    byte yields at least one beat, the final one with rsp_last set (it may hold
//    zero bytes). page_end and status ride on the result beats.
//  - csr_*: APB-style port, line_size at byte address 0, pready tied high.
//    Write it only while idle; a write restarts the line history.
// Timing: an input byte is decoded, then its decoded bytes pass through the line
//  ring (one ring access a cycle while the sequencer is not held), then the final
//  beat is posted. Copy runs reach 512 bytes, repeat runs reach 255 bytes.
// Reset: synchronous; clears decoder state, errors and page parity, line_size
//  returns to 512. The ring holds no valid data until a full line is decoded.
// Stall: a full chunk waits in the result register; when a second chunk is ready
//  and rsp_ready is low the sequencer holds, and no byte is lost.
// Depends on rldd_pkg, rldd_ctrl, rldd_dp, rldd_ram.
module raster_line_delta_decoder #(
   parameter int MAX_LINE_BYTES   = 512,
   parameter int BYTES_PER_RESULT = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_stream_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_out_data,
   output logic [3:0]  rsp_byte_count,
   output logic        rsp_page_end,
   output logic [2:0]  rsp_status,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import rldd_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic [$clog2(MAX_LINE_BYTES)-1:0]   pos;
   logic [$clog2(MAX_LINE_BYTES+1)-1:0] len;
   logic                                line_done;

   assign csr_pready = 1'b1;

   rldd_ctrl #(.MAX_LINE_BYTES(MAX_LINE_BYTES)) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_stream_byte (req_stream_byte),
      .cmd             (cmd),
      .stat            (stat),
      .pos             (pos),
      .len             (len),
      .line_done       (line_done)
   );

   rldd_dp #(
      .MAX_LINE_BYTES   (MAX_LINE_BYTES),
      .BYTES_PER_RESULT (BYTES_PER_RESULT)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .cmd            (cmd),
      .stat           (stat),
      .pos            (pos),
      .len            (len),
      .line_done      (line_done),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_data   (rsp_out_data),
      .rsp_byte_count (rsp_byte_count),
      .rsp_page_end   (rsp_page_end),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );
endmodule

// ----- hdl/rldd_checker.sv -----
// Port-level checks of the raster line delta decoder, bound to the top level.
// Depends on rldd_pkg and raster_line_delta_decoder_assert.svh.
`include "raster_line_delta_decoder_assert.svh"
module rldd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_byte_count,
   input logic       rsp_page_end,
   input logic [2:0] rsp_status,
   input logic       rsp_last
);
   import rldd_pkg::*;

   // a beat never carries more than one chunk of bytes
   `RLDD_ASSERT_IMPLY(a_count_max, rsp_valid, rsp_byte_count <= 4'd8)
   // page end only on the final beat of a byte
   `RLDD_ASSERT_IMPLY(a_pe_last, rsp_valid && rsp_page_end, rsp_last)
   // once in error, no decoded bytes come out
   `RLDD_ASSERT_IMPLY(a_err_empty, rsp_valid && rsp_status != STAT_OK, rsp_byte_count == 4'd0)
   // one byte in flight at a time
   `RLDD_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready)
   // a stalled beat stays up
   `RLDD_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready, rsp_valid)
endmodule

bind raster_line_delta_decoder rldd_checker u_rldd_checker (.*);
